@@ hdl/priority_ring_turn_queue_assert.svh @@
// Assertion macros used by the turn queue datapath.
`ifndef PRIORITY_RING_TURN_QUEUE_ASSERT_SVH
`define PRIORITY_RING_TURN_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRTQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("turn queue assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PRTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("turn queue assertion failed");

`endif

@@ hdl/prtq_pkg.sv @@
// Shared types and constants for the turn queue.
package prtq_pkg;

  localparam int unsigned CapacityDefault = 32;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_ROTATE = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_DELETE = 2'd3
  } req_e;

  typedef struct packed {
    req_e       req_type;
    logic [7:0] entry_id;
    logic [7:0] initiative;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
  } in_req_t;

  typedef struct packed {
    logic       found;
    logic [7:0] found_id;
    logic       head_valid;
    logic [7:0] head_id;
    logic [5:0] entry_count;
    logic       overflow;
  } out_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic compare;
    logic prefix;
    logic update;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_blocked;
  } dp_status_t;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_PFX  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_e;

endpackage

@@ hdl/prtq_ctrl.sv @@
// Sequencing controller for the turn queue.
module prtq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  prtq_pkg::dp_status_t  status_i,
  output prtq_pkg::ctl_cmd_t    cmd_o
);
  import prtq_pkg::*;

  state_e state_q, state_d;

  // New requests are taken only between operations.
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = ST_PFX;
      end
      ST_PFX: begin
        cmd_o.prefix = 1'b1;
        state_d      = ST_UPD;
      end
      ST_UPD: begin
        // Commit only when the result register can take the new result.
        if (!status_i.out_blocked) begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/prtq_datapath.sv @@
// Cell chain, compare and prefix logic, and result register of the turn queue.
`include "priority_ring_turn_queue_assert.svh"

module prtq_datapath #(
  parameter int unsigned Capacity = prtq_pkg::CapacityDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  prtq_pkg::in_req_t     in_req_i,
  input  prtq_pkg::ctl_cmd_t    cmd_i,
  output prtq_pkg::dp_status_t  status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output prtq_pkg::out_rsp_t    out_rsp_o
);
  import prtq_pkg::*;

  localparam int unsigned CntW   = $clog2(Capacity + 1);
  localparam int unsigned Levels = $clog2(Capacity);

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] prio;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
  } cell_t;

  cell_t               cell_q [Capacity];
  cell_t               cell_d [Capacity];
  in_req_t             req_q;
  logic [CntW-1:0]     count_q, count_d, last_idx;
  logic [Capacity-1:0] in_ring, hit_d, hit_q, before_d, before_q, sel;
  logic [Capacity-1:0] acc, nxt;
  logic                ring_full, any_hit, is_search;
  logic [7:0]          match_id;
  cell_t               new_cell;
  out_rsp_t            rsp_d, rsp_q;
  logic                out_valid_q;

  // Occupancy mask of the chain.
  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      in_ring[i] = CntW'(i) < count_q;
    end
  end

  // Per-cell compare: insertion stop points, or coordinate matches.
  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      if (req_q.req_type == REQ_INSERT) begin
        if (i == 0) begin
          hit_d[i] = (count_q == '0) || (cell_q[0].prio < req_q.initiative);
        end else begin
          hit_d[i] = (CntW'(i) == count_q) ||
                     (in_ring[i] && (cell_q[i].prio < req_q.initiative));
        end
      end else begin
        hit_d[i] = in_ring[i] && (cell_q[i].pos_x == req_q.pos_x) &&
                   (cell_q[i].pos_y == req_q.pos_y);
      end
    end
  end

  // Log-depth prefix OR; a cell is past the first hit when any lower cell hit.
  always_comb begin
    acc = hit_q;
    for (int l = 0; l < Levels; l++) begin
      nxt = acc;
      for (int i = 0; i < Capacity; i++) begin
        if (i >= (1 << l)) begin
          nxt[i] = acc[i] | acc[i - (1 << l)];
        end
      end
      acc = nxt;
    end
    before_d = {acc[Capacity-2:0], 1'b0};
  end

  // Selected cell and the identifier it holds.
  assign sel       = hit_q & ~before_q;
  assign any_hit   = hit_q[Capacity-1] | before_q[Capacity-1];
  assign ring_full = (count_q == CntW'(Capacity));
  assign last_idx  = count_q - CntW'(1);
  assign is_search = (req_q.req_type == REQ_FIND) || (req_q.req_type == REQ_DELETE);
  assign new_cell  = '{id: req_q.entry_id, prio: req_q.initiative,
                       pos_x: req_q.pos_x, pos_y: req_q.pos_y};

  always_comb begin
    match_id = '0;
    for (int i = 0; i < Capacity; i++) begin
      match_id = match_id | ({8{sel[i]}} & cell_q[i].id);
    end
  end

  // Next contents of the chain for the request in hand.
  always_comb begin
    cell_d  = cell_q;
    count_d = count_q;
    case (req_q.req_type)
      REQ_INSERT: begin
        if (!ring_full) begin
          if (sel[0]) begin
            cell_d[0] = new_cell;
          end
          for (int i = 1; i < Capacity; i++) begin
            if (sel[i]) begin
              cell_d[i] = new_cell;
            end else if (before_q[i]) begin
              cell_d[i] = cell_q[i-1];
            end
          end
          count_d = count_q + CntW'(1);
        end
      end
      REQ_ROTATE: begin
        if (count_q > CntW'(1)) begin
          for (int i = 0; i < Capacity - 1; i++) begin
            if (CntW'(i) < last_idx) begin
              cell_d[i] = cell_q[i+1];
            end
          end
          for (int i = 0; i < Capacity; i++) begin
            if (CntW'(i) == last_idx) begin
              cell_d[i] = cell_q[0];
            end
          end
        end
      end
      REQ_FIND: begin
        count_d = count_q;
      end
      REQ_DELETE: begin
        if (any_hit) begin
          for (int i = 0; i < Capacity - 1; i++) begin
            if (sel[i] || before_q[i]) begin
              cell_d[i] = cell_q[i+1];
            end
          end
          count_d = count_q - CntW'(1);
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  // Result fields, taken from the chain after the update.
  always_comb begin
    rsp_d             = '0;
    rsp_d.found       = is_search && any_hit;
    rsp_d.found_id    = rsp_d.found ? match_id : 8'd0;
    rsp_d.head_valid  = (count_d != '0);
    rsp_d.head_id     = rsp_d.head_valid ? cell_d[0].id : 8'd0;
    rsp_d.entry_count = 6'(count_d);
    rsp_d.overflow    = (req_q.req_type == REQ_INSERT) && ring_full;
  end

  // Request, compare and prefix registers, and the chain and result registers on update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_req_i;
    end
    if (cmd_i.compare) begin
      hit_q <= hit_d;
    end
    if (cmd_i.prefix) begin
      before_q <= before_d;
    end
    if (cmd_i.update) begin
      cell_q <= cell_d;
      rsp_q  <= rsp_d;
    end
  end

  // Entry count and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o          = out_valid_q;
  assign out_rsp_o            = rsp_q;

  // The ring never holds more than its capacity.
  `PRTQ_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(Capacity))
  // An update never overwrites a result that is still waiting.
  `PRTQ_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd_i.update, !status_o.out_blocked)
  // Every update presents a result in the next cycle.
  `PRTQ_ASSERT_NEXT(a_update_valid, clk_i, rst_ni, cmd_i.update, out_valid_q)
  // A find leaves the entry count alone.
  `PRTQ_ASSERT_NEXT(a_find_count, clk_i, rst_ni, cmd_i.update && (req_q.req_type == REQ_FIND), $stable(count_q))

endmodule

@@ hdl/priority_ring_turn_queue.sv @@
// Top level of the turn queue: controller and cell-chain datapath.
//
//   Channel | Direction | Handshake               | Payload
//   in      | input     | in_valid_i / in_stall_o  | in_req_i  (prtq_pkg::in_req_t)
//   out     | output    | out_valid_o / out_stall_i| out_rsp_o (prtq_pkg::out_rsp_t)
//
// Each request passes through four steps: accept, per-cell compare, prefix OR over the
// chain, then the shift update that loads the result register.
// The result is valid the cycle after the update; a new request is taken then.
// An output stall holds the controller in its update step until the result is taken.
// Reset empties the ring and clears the controller; entry contents are not reset.
module priority_ring_turn_queue #(
  parameter int unsigned Capacity = prtq_pkg::CapacityDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  prtq_pkg::in_req_t   in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output prtq_pkg::out_rsp_t  out_rsp_o
);
  import prtq_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // Sequencer.
  prtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Entry storage and search logic.
  prtq_datapath #(
    .Capacity (Capacity)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

@@ tb/sv/prtq_checker.sv @@
// Response checker for the turn queue: tracks the ring, predicts and compares responses.
module prtq_checker
  import prtq_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_req_t     in_req_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_rsp_t    out_rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  // One entry of the turn order.
  typedef struct packed {
    logic [7:0] ident;
    logic [7:0] initiative;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
  } turn_slot_t;

  // Shadow ring: index 0 is the head, ring_len - 1 the tail.
  turn_slot_t  turn_ring[Capacity];
  int unsigned ring_len;
  out_rsp_t    expected_rsp_q[$];
  int unsigned mismatches;
  int unsigned responses;

  // Serves one request against the shadow ring and returns the response it should give.
  function automatic out_rsp_t serve_request(in_req_t req);
    out_rsp_t   rsp;
    turn_slot_t old_head;
    int         pos;
    int         idx;
    rsp = '0;
    case (req.req_type)
      REQ_INSERT: begin
        if (ring_len >= Capacity) begin
          rsp.overflow = 1'b1;
        end else begin
          // A higher initiative than the head takes the head; otherwise skip the
          // run of entries from the second one that are at least as high.
          if (ring_len == 0 || turn_ring[0].initiative < req.initiative) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < ring_len && turn_ring[pos].initiative >= req.initiative) pos++;
          end
          for (idx = ring_len; idx > pos; idx--) turn_ring[idx] = turn_ring[idx - 1];
          turn_ring[pos] = '{req.entry_id, req.initiative, req.pos_x, req.pos_y};
          ring_len++;
        end
      end
      REQ_ROTATE: begin
        // The head moves to the tail.
        if (ring_len > 1) begin
          old_head = turn_ring[0];
          for (idx = 0; idx + 1 < ring_len; idx++) turn_ring[idx] = turn_ring[idx + 1];
          turn_ring[ring_len - 1] = old_head;
        end
      end
      default: begin
        // Find and delete act on the first coordinate match from the head.
        pos = 0;
        while (pos < ring_len &&
               !(turn_ring[pos].pos_x == req.pos_x && turn_ring[pos].pos_y == req.pos_y)) pos++;
        if (pos < ring_len) begin
          rsp.found    = 1'b1;
          rsp.found_id = turn_ring[pos].ident;
          if (req.req_type == REQ_DELETE) begin
            for (idx = pos; idx + 1 < ring_len; idx++) turn_ring[idx] = turn_ring[idx + 1];
            ring_len--;
          end
        end
      end
    endcase
    rsp.head_valid  = (ring_len > 0);
    rsp.head_id     = (ring_len > 0) ? turn_ring[0].ident : 8'h00;
    rsp.entry_count = 6'(ring_len);
    return rsp;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic compare_response(out_rsp_t got, out_rsp_t want);
    if (got.found !== want.found) begin
      report_mismatch("found", 32'(got.found), 32'(want.found));
    end
    if (got.found_id !== want.found_id) begin
      report_mismatch("found_id", 32'(got.found_id), 32'(want.found_id));
    end
    if (got.head_valid !== want.head_valid) begin
      report_mismatch("head_valid", 32'(got.head_valid), 32'(want.head_valid));
    end
    if (got.head_id !== want.head_id) begin
      report_mismatch("head_id", 32'(got.head_id), 32'(want.head_id));
    end
    if (got.entry_count !== want.entry_count) begin
      report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
    end
    if (got.overflow !== want.overflow) begin
      report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
    end
  endtask

  // Watch both channels: predict on each accepted request, compare on each accepted response.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_len = 0;
      expected_rsp_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
      checked_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) expected_rsp_q.push_back(serve_request(in_req_i));
      if (out_valid_i && !out_stall_i) begin
        responses++;
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("response with no request outstanding", 32'(out_rsp_i), 32'd0);
        end else begin
          compare_response(out_rsp_i, expected_rsp_q.pop_front());
        end
      end
      pending_o    <= expected_rsp_q.size();
      fail_count_o <= mismatches;
      checked_o    <= responses;
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the turn queue: clock, reset, request stimulus, stalls and verdict.
module tb_top;
  import prtq_pkg::*;

  localparam int unsigned RingSize      = CapacityDefault;
  localparam int unsigned HoldOffCycles = 150;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MixedPerPhase = 70;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_req_t     in_req;
  logic        out_valid;
  logic        out_stall;
  out_rsp_t    out_rsp;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  // Coordinates held in the ring, as a multiset; only its size and contents matter here.
  logic [15:0] live_keys[$];
  int unsigned idle_pct;
  int unsigned stall_pct;
  bit          hold_off_req;
  int unsigned requests_sent;
  int unsigned dropped_inserts;

  always #6 clk = ~clk;

  priority_ring_turn_queue #(.Capacity(RingSize)) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  prtq_checker #(.Capacity(RingSize)) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // Coordinates are often drawn from a tiny range so that duplicates and hits are common.
  function automatic logic [7:0] pick_coord();
    return ($urandom_range(1) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
  endfunction

  function automatic in_req_t make_req(req_e op, logic [7:0] id, logic [7:0] pri,
                                       logic [7:0] x, logic [7:0] y);
    in_req_t r;
    r.req_type   = op;
    r.entry_id   = id;
    r.initiative = pri;
    r.pos_x      = x;
    r.pos_y      = y;
    return r;
  endfunction

  // Random request; unused fields carry noise, searches mostly hit a live entry.
  function automatic in_req_t random_request(int unsigned insert_pct);
    in_req_t     r;
    int unsigned roll;
    logic [15:0] key;
    r = make_req(REQ_ROTATE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 pick_coord(), pick_coord());
    roll = $urandom_range(99);
    if (roll < insert_pct) begin
      r.req_type = REQ_INSERT;
      // Coarse initiatives produce plenty of ties.
      if ($urandom_range(1) == 0) r.initiative = 8'($urandom_range(3) * 85);
    end else if (roll >= insert_pct + 15) begin
      r.req_type = ($urandom_range(1) == 0) ? REQ_FIND : REQ_DELETE;
      if (live_keys.size() != 0 && $urandom_range(99) < 70) begin
        key     = live_keys[$urandom_range(live_keys.size() - 1)];
        r.pos_x = key[15:8];
        r.pos_y = key[7:0];
      end
    end
    return r;
  endfunction

  // Offers one request, with an optional idle gap first, and waits until it is taken.
  task automatic send(in_req_t r);
    int idx;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_req   <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    // Keep the coordinate multiset in step with the ring.
    case (r.req_type)
      REQ_INSERT: begin
        if (live_keys.size() < RingSize) live_keys.push_back({r.pos_x, r.pos_y});
        else dropped_inserts++;
      end
      REQ_DELETE: begin
        for (idx = 0; idx < live_keys.size(); idx++) begin
          if (live_keys[idx] == {r.pos_x, r.pos_y}) break;
        end
        if (idx < live_keys.size()) live_keys.delete(idx);
      end
      default: ;
    endcase
  endtask

  // Stops offering and waits until every response has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Corner cases: empty and one-entry ring, head takeover, ties, duplicate coordinates.
  task automatic run_directed();
    send(make_req(REQ_FIND,   8'h00, 8'h00, 8'h00, 8'h00));
    send(make_req(REQ_DELETE, 8'hFF, 8'hFF, 8'h00, 8'h00));
    send(make_req(REQ_ROTATE, 8'h00, 8'h00, 8'h00, 8'h00));
    send(make_req(REQ_INSERT, 8'h00, 8'h00, 8'h00, 8'h00));
    send(make_req(REQ_FIND,   8'h00, 8'h00, 8'hFF, 8'hFF));
    send(make_req(REQ_DELETE, 8'h00, 8'h00, 8'hFF, 8'h00));
    send(make_req(REQ_ROTATE, 8'h00, 8'h00, 8'h00, 8'h00));
    send(make_req(REQ_INSERT, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send(make_req(REQ_INSERT, 8'h01, 8'hFF, 8'h01, 8'h01));
    send(make_req(REQ_INSERT, 8'h02, 8'h00, 8'h01, 8'h01));
    send(make_req(REQ_INSERT, 8'h03, 8'h80, 8'h80, 8'h7F));
    send(make_req(REQ_FIND,   8'h00, 8'h00, 8'h01, 8'h01));
    send(make_req(REQ_DELETE, 8'h00, 8'h00, 8'h01, 8'h01));
    send(make_req(REQ_FIND,   8'h00, 8'h00, 8'h01, 8'h01));
    send(make_req(REQ_ROTATE, 8'h00, 8'h00, 8'h00, 8'h00));
    send(make_req(REQ_ROTATE, 8'h00, 8'h00, 8'h00, 8'h00));
    send(make_req(REQ_INSERT, 8'hAA, 8'h55, 8'h55, 8'hAA));
    send(make_req(REQ_DELETE, 8'h00, 8'h00, 8'hFF, 8'hFF));
    send(make_req(REQ_FIND,   8'h00, 8'h00, 8'h80, 8'h7F));
    send(make_req(REQ_INSERT, 8'h55, 8'hAA, 8'hAA, 8'h55));
    send(make_req(REQ_FIND,   8'h00, 8'h00, 8'h55, 8'hAA));
  endtask

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        out_stall    <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
      end
      out_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: ends the run when nothing is accepted for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no request or response accepted for %0d cycles", $realtime, quiet);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus: reset, directed cases, then four phases of fill, mixed traffic and empty.
  initial begin : stimulus
    in_req_t     r;
    int unsigned phase;
    int unsigned insert_pct;
    logic [15:0] key;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_req   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 66; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 66; end
        default: begin idle_pct = 30; stall_pct <= 30; end
      endcase
      // The first fill runs into a long output hold-off so the block backs up.
      if (phase == 0) hold_off_req <= 1'b1;

      // Fill the ring to capacity, then push a few inserts into the full ring.
      while (live_keys.size() < RingSize) send(random_request(100));
      repeat (3) send(random_request(100));

      // Mixed traffic, biased to keep the ring between nearly empty and full.
      repeat (MixedPerPhase) begin
        insert_pct = (live_keys.size() < 8) ? 55 : (live_keys.size() > 26) ? 20 : 35;
        send(random_request(insert_pct));
      end

      // Delete every entry by its coordinates, then search the empty ring.
      while (live_keys.size() != 0) begin
        key     = live_keys[$urandom_range(live_keys.size() - 1)];
        r       = random_request(0);
        r.req_type = REQ_DELETE;
        r.pos_x = key[15:8];
        r.pos_y = key[7:0];
        send(r);
      end
      r = random_request(0);
      r.req_type = REQ_FIND;
      send(r);
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Run covered %0d requests (%0d inserts into a full ring), %0d responses compared.",
             requests_sent, dropped_inserts, checked);
    $display("Traffic mixes: free flow, sparse requests, heavy output stalls, both, one long hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ priority_ring_turn_queue.f @@
+incdir+hdl
hdl/prtq_pkg.sv
hdl/prtq_ctrl.sv
hdl/prtq_datapath.sv
hdl/priority_ring_turn_queue.sv
tb/sv/prtq_checker.sv
tb/sv/tb_top.sv
